@@ src/linear_probe_hash_table_macros.svh @@
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lpht_pkg.sv @@
package lpht_pkg;

    // Reciprocal precision for the hash modulo: exact for sums below 2^11
    // and table sizes up to 2^12.
    localparam int HASH_SHIFT = 24;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_SUM,
        STEP_QUOT,
        STEP_HOME,
        STEP_READ,
        STEP_CHECK,
        STEP_OUT
    } t_step;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_CLR_LAST,
        COND_IN_VALID,
        COND_SKIP,
        COND_PROBE_DONE,
        COND_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic  clr_wr;
        logic  in_ready;
        logic  ld_sum;
        logic  ld_quot;
        logic  ld_home;
        logic  mem_rd;
        logic  resolve;
        logic  out_valid;
        t_cond cond;
        t_step next_step;
        t_step jump_step;
    } t_uword;

    typedef struct packed {
        logic clr_last;
        logic skip;
        logic probe_done;
    } t_dp_flags;

    // Microcode ROM: jump_step is taken when cond holds, else next_step.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '0;
        w.cond = COND_NONE;
        case (step)
            STEP_CLEAR: begin
                w.clr_wr    = 1'b1;
                w.cond      = COND_CLR_LAST;
                w.next_step = STEP_CLEAR;
                w.jump_step = STEP_IDLE;
            end
            STEP_IDLE: begin
                w.in_ready  = 1'b1;
                w.cond      = COND_IN_VALID;
                w.next_step = STEP_IDLE;
                w.jump_step = STEP_SUM;
            end
            STEP_SUM: begin
                w.ld_sum    = 1'b1;
                w.next_step = STEP_QUOT;
                w.jump_step = STEP_QUOT;
            end
            STEP_QUOT: begin
                w.ld_quot   = 1'b1;
                w.next_step = STEP_HOME;
                w.jump_step = STEP_HOME;
            end
            STEP_HOME: begin
                w.ld_home   = 1'b1;
                w.cond      = COND_SKIP;
                w.next_step = STEP_READ;
                w.jump_step = STEP_OUT;
            end
            STEP_READ: begin
                w.mem_rd    = 1'b1;
                w.next_step = STEP_CHECK;
                w.jump_step = STEP_CHECK;
            end
            STEP_CHECK: begin
                w.resolve   = 1'b1;
                w.cond      = COND_PROBE_DONE;
                w.next_step = STEP_READ;
                w.jump_step = STEP_OUT;
            end
            STEP_OUT: begin
                w.out_valid = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.next_step = STEP_OUT;
                w.jump_step = STEP_IDLE;
            end
            default: begin
                w.next_step = STEP_IDLE;
                w.jump_step = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/lpht_sequencer.sv @@
module lpht_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  lpht_pkg::t_dp_flags i_flags,
    output lpht_pkg::t_uword   o_uword
);

    lpht_pkg::t_step  r_step;
    lpht_pkg::t_step  n_step;
    lpht_pkg::t_uword w_uword;
    logic             w_cond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= lpht_pkg::STEP_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_uword = lpht_pkg::ucode(r_step);
        case (w_uword.cond)
            lpht_pkg::COND_NONE:       w_cond = 1'b0;
            lpht_pkg::COND_CLR_LAST:   w_cond = i_flags.clr_last;
            lpht_pkg::COND_IN_VALID:   w_cond = i_in_valid;
            lpht_pkg::COND_SKIP:       w_cond = i_flags.skip;
            lpht_pkg::COND_PROBE_DONE: w_cond = i_flags.probe_done;
            lpht_pkg::COND_OUT_FREE:   w_cond = !i_out_stall;
            default:                   w_cond = 1'b0;
        endcase
        n_step  = w_cond ? w_uword.jump_step : w_uword.next_step;
        o_uword = w_uword;
    end

endmodule

@@ src/lpht_datapath.sv @@
module lpht_datapath #(
    parameter int SLOT_COUNT = 16,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpht_pkg::t_uword    i_uword,
    input  logic                i_accept,
    input  logic [1:0]          i_func,
    input  logic [63:0]         i_key_word,
    input  logic [31:0]         i_value_in,
    output lpht_pkg::t_dp_flags o_flags,
    output logic [2:0]          o_status,
    output logic [31:0]         o_value_out,
    output logic [4:0]          o_entry_count
);

    localparam int IW    = $clog2(SLOT_COUNT);
    localparam int KW    = 8 * KEY_BYTES;
    localparam int VW    = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int MW    = 1 + KW + VW;
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int SW    = $clog2(KEY_BYTES * 255 + 1);
    localparam int PW    = SW + lpht_pkg::HASH_SHIFT;
    localparam int TW    = SW + IW + 1;
    localparam int RECIP = ((1 << lpht_pkg::HASH_SHIFT) + SLOT_COUNT - 1) / SLOT_COUNT;

    logic [MW-1:0]     r_mem [SLOT_COUNT];
    logic [MW-1:0]     r_rdata;
    logic [1:0]        r_func;
    logic [KW-1:0]     r_key;
    logic [VW-1:0]     r_val;
    logic [SW-1:0]     r_sum;
    logic [SW-1:0]     r_quot;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_n;
    logic [CW-1:0]     r_count;
    lpht_pkg::t_status r_status;
    logic [VW-1:0]     r_vout;

    logic [IW-1:0]     n_idx;
    logic [IW-1:0]     n_n;
    logic [CW-1:0]     n_count;
    lpht_pkg::t_status n_status;
    logic [VW-1:0]     n_vout;

    logic [SW-1:0]     w_sum;
    logic [PW-1:0]     w_prod;
    logic [TW-1:0]     w_qt;
    logic [TW-1:0]     w_rem;
    logic [IW-1:0]     w_home;
    logic [IW-1:0]     w_idx_inc;
    logic              w_occ;
    logic [KW-1:0]     w_skey;
    logic [VW-1:0]     w_sval;
    logic              w_match;
    logic              w_last;
    logic              w_we;
    logic [MW-1:0]     w_wdata;

    // Hash: byte sum, then modulo via reciprocal multiply over two steps.
    always_comb begin
        w_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_sum = w_sum + SW'(r_key[8*b +: 8]);
        end
    end

    assign w_prod = PW'(r_sum) * PW'(RECIP);
    assign w_qt   = TW'(r_quot) * TW'(SLOT_COUNT);
    assign w_rem  = TW'(r_sum) - w_qt;
    assign w_home = (w_rem >= TW'(SLOT_COUNT)) ? IW'(w_rem - TW'(SLOT_COUNT)) : IW'(w_rem);

    assign w_idx_inc = (r_idx == IW'(SLOT_COUNT - 1)) ? '0 : r_idx + IW'(1);

    assign w_occ   = r_rdata[MW-1];
    assign w_skey  = r_rdata[KW+VW-1:VW];
    assign w_sval  = r_rdata[VW-1:0];
    assign w_match = w_occ && (w_skey == r_key);
    assign w_last  = (r_n == IW'(SLOT_COUNT - 1));

    always_comb begin
        n_idx    = r_idx;
        n_n      = r_n;
        n_count  = r_count;
        n_status = r_status;
        n_vout   = r_vout;
        w_we     = 1'b0;
        w_wdata  = '0;
        if (i_uword.clr_wr) begin
            w_we  = 1'b1;
            n_idx = w_idx_inc;
        end
        if (i_accept) begin
            n_status = lpht_pkg::ST_NOT_FOUND;
            n_vout   = '0;
        end
        if (i_uword.ld_home) begin
            n_idx = w_home;
            n_n   = '0;
        end
        if (i_uword.resolve) begin
            if (!w_occ) begin
                if (r_func == lpht_pkg::FUNC_INSERT) begin
                    w_we     = 1'b1;
                    w_wdata  = {1'b1, r_key, r_val};
                    n_status = lpht_pkg::ST_INSERTED;
                    n_count  = r_count + CW'(1);
                end
            end else if (w_match) begin
                case (r_func)
                    lpht_pkg::FUNC_INSERT: begin
                        w_we     = 1'b1;
                        w_wdata  = {1'b1, r_key, r_val};
                        n_status = lpht_pkg::ST_UPDATED;
                    end
                    lpht_pkg::FUNC_LOOKUP: begin
                        n_status = lpht_pkg::ST_FOUND;
                        n_vout   = w_sval;
                    end
                    lpht_pkg::FUNC_REMOVE: begin
                        // no tombstone: only the occupied mark drops
                        w_we     = 1'b1;
                        w_wdata  = {1'b0, w_skey, w_sval};
                        n_status = lpht_pkg::ST_REMOVED;
                        n_count  = r_count - CW'(1);
                    end
                    default: begin
                    end
                endcase
            end else if (w_last) begin
                if (r_func == lpht_pkg::FUNC_INSERT) begin
                    n_status = lpht_pkg::ST_FULL;
                end
            end else begin
                n_idx = w_idx_inc;
                n_n   = r_n + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_func <= i_func;
            r_key  <= i_key_word[KW-1:0];
            r_val  <= i_value_in[VW-1:0];
        end
        if (i_uword.ld_sum) begin
            r_sum <= w_sum;
        end
        if (i_uword.ld_quot) begin
            r_quot <= SW'(w_prod >> lpht_pkg::HASH_SHIFT);
        end
        r_n      <= n_n;
        r_status <= n_status;
        r_vout   <= n_vout;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        if (i_uword.mem_rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    assign o_flags.clr_last   = (r_idx == IW'(SLOT_COUNT - 1));
    assign o_flags.skip       = !((r_func == lpht_pkg::FUNC_INSERT) ||
                                  (r_func == lpht_pkg::FUNC_LOOKUP) ||
                                  (r_func == lpht_pkg::FUNC_REMOVE)) ||
                                ((r_func == lpht_pkg::FUNC_REMOVE) && (r_count == '0));
    assign o_flags.probe_done = !w_occ || w_match || w_last;

    assign o_status      = r_status;
    assign o_value_out   = 32'(r_vout);
    assign o_entry_count = 5'(r_count);

endmodule

@@ src/linear_probe_hash_table.sv @@
// Open-addressing hash table with linear probing, SLOT_COUNT slots in one
// single-port-style memory (one write, one registered read per cycle).
// After reset the block sweeps the memory to empty, one slot per cycle, and
// holds o_in_stall high meanwhile. It works on one item at a time: after
// acceptance it forms the key's byte sum, the quotient and the home slot,
// then probes 1 to SLOT_COUNT slots, each with a memory read step and a
// compare step, and then offers its result. An unused operation code, or a
// remove from an empty table, skips the probes.
// The next item is taken the cycle after the result is taken.
module linear_probe_hash_table #(
    parameter int SLOT_COUNT = 16,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key_word,
    input  logic [31:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_value_out,
    output logic [4:0]  o_entry_count
);

    lpht_pkg::t_uword    w_uword;
    lpht_pkg::t_dp_flags w_flags;
    logic                w_accept;

    assign o_in_stall  = !w_uword.in_ready;
    assign o_out_valid = w_uword.out_valid;
    assign w_accept    = i_in_valid && w_uword.in_ready;

    lpht_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_flags     (w_flags),
        .o_uword     (w_uword)
    );

    lpht_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (w_uword),
        .i_accept      (w_accept),
        .i_func        (i_func),
        .i_key_word    (i_key_word),
        .i_value_in    (i_value_in),
        .o_flags       (w_flags),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

`include "linear_probe_hash_table_macros.svh"

    `LPHT_ASSERT_NEXT(a_one_item_in_flight, w_accept, o_in_stall && !o_out_valid, "busy accept")
    `LPHT_ASSERT_NEXT(a_result_not_repeated, o_out_valid && !i_out_stall, !o_out_valid, "repeat")
    `LPHT_ASSERT_NOW(a_value_only_on_found, o_out_valid && (o_status != lpht_pkg::ST_FOUND), o_value_out == '0, "value")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS       = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int POOL_KEYS   = 24;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    typedef enum {PROBE_FULL, PROBE_EMPTY, PROBE_HIT} t_probe;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct {
        lpht_pkg::t_status status;
        logic [31:0]       value;
        logic [4:0]        count;
    } t_response;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_func      = lpht_pkg::FUNC_INSERT;
    logic [63:0] i_key_word  = '0;
    logic [31:0] i_value_in  = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [31:0] o_value_out;
    logic [4:0]  o_entry_count;

    // table shadow
    logic        slot_used   [SLOTS];
    logic [63:0] slot_keys   [SLOTS];
    logic [31:0] slot_values [SLOTS];
    int          live_entries = 0;

    t_response   pending_responses[$];
    t_response   want;
    logic [63:0] key_pool [POOL_KEYS];

    int          error_count  = 0;
    int          idle_cycles  = 0;
    int          burst_left   = 0;
    int          max_gap      = 0;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          stall_phase  = 0;
    t_stall_mode stall_mode   = STALL_NONE;

    linear_probe_hash_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_key_word    (i_key_word),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int home_of(input logic [63:0] key);
        int sum;
        sum = 0;
        for (int b = 0; b < 8; b++) sum += key[8*b +: 8];
        return sum % SLOTS;
    endfunction

    function automatic t_probe probe_slot(input logic [63:0] key, output int pos);
        int idx;
        idx = home_of(key);
        pos = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!slot_used[idx]) begin
                pos = idx;
                return PROBE_EMPTY;
            end
            if (slot_keys[idx] == key) begin
                pos = idx;
                return PROBE_HIT;
            end
            idx = (idx + 1) % SLOTS;
        end
        return PROBE_FULL;
    endfunction

    function automatic t_response apply_request(input logic [1:0] f, input logic [63:0] key,
                                                input logic [31:0] val);
        t_response rsp;
        t_probe    hit;
        int        pos;
        rsp.status = lpht_pkg::ST_NOT_FOUND;
        rsp.value  = '0;
        case (f)
            lpht_pkg::FUNC_INSERT: begin
                hit = probe_slot(key, pos);
                if (hit == PROBE_HIT) begin
                    slot_values[pos] = val;
                    rsp.status = lpht_pkg::ST_UPDATED;
                end else if (hit == PROBE_EMPTY) begin
                    slot_used[pos]   = 1'b1;
                    slot_keys[pos]   = key;
                    slot_values[pos] = val;
                    live_entries++;
                    rsp.status = lpht_pkg::ST_INSERTED;
                end else begin
                    rsp.status = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::FUNC_LOOKUP: begin
                if (probe_slot(key, pos) == PROBE_HIT) begin
                    rsp.status = lpht_pkg::ST_FOUND;
                    rsp.value  = slot_values[pos];
                end
            end
            lpht_pkg::FUNC_REMOVE: begin
                // no tombstone: the slot simply goes empty
                if (live_entries != 0 && probe_slot(key, pos) == PROBE_HIT) begin
                    slot_used[pos] = 1'b0;
                    live_entries--;
                    rsp.status = lpht_pkg::ST_REMOVED;
                end
            end
            default: ;
        endcase
        rsp.count = 5'(live_entries);
        return rsp;
    endfunction

    function automatic logic [63:0] random_key();
        logic [63:0] key;
        key = {$urandom, $urandom};
        for (int b = 0; b < 8; b++) begin
            if ($urandom_range(3, 0) == 0) key[8*b +: 8] = 8'h00;
        end
        return key;
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [63:0] key,
                             input logic [31:0] val);
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_key_word <= key;
        i_value_in <= val;
        do @(posedge i_clk); while (o_in_stall);
        pending_responses.push_back(apply_request(f, key, val));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = (max_gap > 0) ? $urandom_range(max_gap, 1) : 0;
            burst_left = $urandom_range(12, 0);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_directed();
        max_gap    = 3;
        stall_mode = STALL_LIGHT;
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0, 32'h0);
        send_item(lpht_pkg::FUNC_REMOVE, 64'h0, 32'h0);    // remove from empty table
        send_item(FUNC_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0, 32'h0);
        send_item(lpht_pkg::FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        // all of these hash to slot 1; zero bytes inside the key still count
        send_item(lpht_pkg::FUNC_INSERT, 64'h0000_0000_0000_0001, 32'h0000_0001);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0000_0000_0000_0100, 32'h0000_0100);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0001_0000_0000_0000, 32'h0001_0000);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0100_0000_0000_0000, 32'h0100_0000);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0001_0000_0000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0000_0000_0000_0100, 32'hDEAD_BEEF);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0100, 32'h0);
        send_item(lpht_pkg::FUNC_REMOVE, 64'h0000_0000_0000_0100, 32'h0);
        // entries past the removed slot are now out of reach
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0001_0000_0000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0100, 32'h0);
        send_item(lpht_pkg::FUNC_REMOVE, 64'h0000_0000_0000_0100, 32'h0);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0001_0000_0000_0000, 32'h1234_5678);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0, 32'hFFFF_FFFF);
        send_item(lpht_pkg::FUNC_INSERT, 64'h0, 32'hA5A5_5A5A);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0, 32'h0);
        send_item(FUNC_NOP, 64'h0000_0000_0000_0001, 32'h0);
        send_item(lpht_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_table();
        int tries;
        max_gap    = 2;
        stall_mode = STALL_PERIODIC;
        tries = 0;
        while (live_entries < SLOTS && tries < 64) begin
            send_item(lpht_pkg::FUNC_INSERT, random_key(), $urandom);
            tries++;
        end
        send_item(lpht_pkg::FUNC_INSERT, random_key(), $urandom);
        send_item(lpht_pkg::FUNC_LOOKUP, random_key(), $urandom);
        send_item(lpht_pkg::FUNC_REMOVE, random_key(), $urandom);
        send_item(lpht_pkg::FUNC_INSERT, slot_keys[$urandom_range(SLOTS - 1, 0)], $urandom);
        send_item(lpht_pkg::FUNC_LOOKUP, slot_keys[$urandom_range(SLOTS - 1, 0)], $urandom);
        for (int pass = 0; pass < 2; pass++) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_used[s]) send_item(lpht_pkg::FUNC_REMOVE, slot_keys[s], $urandom);
            end
        end
    endtask

    task automatic test_random_mix(input int n_items, input int pool_use, input int gap,
                                   input t_stall_mode mode);
        int          pick;
        logic [1:0]  f;
        logic [63:0] key;
        max_gap    = gap;
        stall_mode = mode;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 40)      f = lpht_pkg::FUNC_INSERT;
            else if (pick < 70) f = lpht_pkg::FUNC_LOOKUP;
            else if (pick < 95) f = lpht_pkg::FUNC_REMOVE;
            else                f = FUNC_NOP;
            if ($urandom_range(9, 0) == 0) key = random_key();
            else key = key_pool[$urandom_range(pool_use - 1, 0)];
            send_item(f, key, $urandom);
        end
    endtask

    task automatic test_backpressure();
        max_gap      = 0;
        stall_mode   = STALL_NONE;
        hold_request = 300;
        for (int i = 0; i < 40; i++) begin
            send_item(i[0] ? lpht_pkg::FUNC_LOOKUP : lpht_pkg::FUNC_INSERT,
                      key_pool[$urandom_range(POOL_KEYS - 1, 0)], $urandom);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result: status %0d value %h count %0d",
                         $time, o_status, o_value_out, o_entry_count);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_value_out !== want.value) begin
                    $display("%0t: value_out mismatch: expected %h actual %h",
                             $time, want.value, o_value_out);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry_count mismatch: expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern, with an optional long hold
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_LIGHT:    i_out_stall <= ($urandom_range(3, 0) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(9, 0) < 7);
                STALL_PERIODIC: i_out_stall <= (stall_phase % 8 < 3);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    // watchdog: nothing accepted on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s]   = 1'b0;
            slot_keys[s]   = '0;
            slot_values[s] = '0;
        end
        for (int k = 0; k < POOL_KEYS; k++) key_pool[k] = random_key();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_random_mix(500, 8, 6, STALL_HEAVY);
        test_backpressure();
        test_random_mix(400, POOL_KEYS, 4, STALL_LIGHT);
        test_random_mix(250, 16, 0, STALL_NONE);
        test_random_mix(200, POOL_KEYS, 3, STALL_PERIODIC);

        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
